/* rtl/assert_macros.svh */
// Assertion macros shared by the segment intersection test RTL.
// Depends on nothing; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside of reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

/* rtl/sit_pkg.sv */
// Package for the segment intersection test: widths, types and codes.
// Used by sit_front, sit_queue, sit_back and segment_intersection_test.
package sit_pkg;

   // Coordinate width and the widths that follow from it.
   localparam int COORD_BITS = 13;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;

   // Number of products formed for each word in the back end.
   localparam int NUM_PROD = 6;

   // Queue between front and back end (power of two depth).
   localparam int MID_DEPTH    = 4;
   localparam int MID_PTR_BITS = $clog2(MID_DEPTH);
   localparam int MID_CNT_BITS = $clog2(MID_DEPTH + 1);

   // Result queue at the output (power of two depth).
   localparam int OUT_DEPTH    = 8;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;

   // Geometry case reported with each result.
   typedef enum logic [2:0] {
      KIND_BOTH_VERT = 3'd0,
      KIND_A_VERT    = 3'd1,
      KIND_B_VERT    = 3'd2,
      KIND_GENERAL   = 3'd3,
      KIND_PARALLEL  = 3'd4
   } kind_type;

   // Classified word handed from the front end to the back end.
   typedef struct packed {
      kind_type                     kind;
      logic                         pre_hit;
      diff_type [NUM_PROD-1:0]      op_x;
      diff_type [NUM_PROD-1:0]      op_y;
   } mid_word_type;

endpackage

/* rtl/sit_front.sv */
// Front end of the segment intersection test: accepts words, classifies the
// segment pair and forms the multiplier operands. Depends on sit_pkg.
module sit_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  sit_pkg::coord_type               a_start_x,
   input  sit_pkg::coord_type               a_start_y,
   input  sit_pkg::coord_type               a_end_x,
   input  sit_pkg::coord_type               a_end_y,
   input  sit_pkg::coord_type               b_start_x,
   input  sit_pkg::coord_type               b_start_y,
   input  sit_pkg::coord_type               b_end_x,
   input  sit_pkg::coord_type               b_end_y,
   input  logic [sit_pkg::MID_CNT_BITS-1:0] mid_level,
   output logic                             word_valid,
   output sit_pkg::mid_word_type            word
);

   // Sign-extending difference of two coordinates.
   function automatic sit_pkg::diff_type dsub(sit_pkg::coord_type a, sit_pkg::coord_type b);
      return sit_pkg::diff_type'(a) - sit_pkg::diff_type'(b);
   endfunction

   logic                  accept;
   logic                  word_valid_ff, word_valid_in;
   sit_pkg::mid_word_type word_ff, word_in;

   logic               a_vert, b_vert, sel_a;
   sit_pkg::coord_type vx, vy0, vy1, p0x, p0y, p1x, p1y, vmin, vmax;
   sit_pkg::coord_type a_lo, a_hi, b_lo, b_hi;
   logic               x_within, x_neg, both_hit;

   // Hold off the producer while the queue could not take every word in flight.
   always_comb begin
      full = (sit_pkg::MID_CNT_BITS'(mid_level) + sit_pkg::MID_CNT_BITS'(word_valid_ff))
             >= sit_pkg::MID_CNT_BITS'(sit_pkg::MID_DEPTH);
      accept = push && !full;
   end

   // Vertical tests and selection of the vertical and the other segment.
   always_comb begin
      a_vert = (a_start_x == a_end_x);
      b_vert = (b_start_x == b_end_x);
      sel_a  = a_vert;
      vx  = sel_a ? a_start_x : b_start_x;
      vy0 = sel_a ? a_start_y : b_start_y;
      vy1 = sel_a ? a_end_y   : b_end_y;
      p0x = sel_a ? b_start_x : a_start_x;
      p0y = sel_a ? b_start_y : a_start_y;
      p1x = sel_a ? b_end_x   : a_end_x;
      p1y = sel_a ? b_end_y   : a_end_y;
      vmin = (vy0 < vy1) ? vy0 : vy1;
      vmax = (vy0 < vy1) ? vy1 : vy0;
      x_within = ((vx >= p0x) && (vx <= p1x)) || ((vx >= p1x) && (vx <= p0x));
      x_neg    = (p1x < p0x);
   end

   // Both vertical: same x and overlapping closed y ranges.
   always_comb begin
      a_lo = (a_start_y < a_end_y) ? a_start_y : a_end_y;
      a_hi = (a_start_y < a_end_y) ? a_end_y   : a_start_y;
      b_lo = (b_start_y < b_end_y) ? b_start_y : b_end_y;
      b_hi = (b_start_y < b_end_y) ? b_end_y   : b_start_y;
      both_hit = (a_start_x == b_start_x) && (a_lo <= b_hi) && (b_lo <= a_hi);
   end

   // Build the word: case, early flag and the six operand pairs.
   always_comb begin
      word_in = '0;
      if (a_vert && b_vert) begin
         word_in.kind    = sit_pkg::KIND_BOTH_VERT;
         word_in.pre_hit = both_hit;
      end else if (a_vert || b_vert) begin
         if (a_vert) begin
            word_in.kind = sit_pkg::KIND_A_VERT;
         end else begin
            word_in.kind = sit_pkg::KIND_B_VERT;
         end
         word_in.pre_hit = x_within;
         // Line height at vx against the y range, scaled by the x span.
         word_in.op_x[0] = x_neg ? dsub(p0y, p1y) : dsub(p1y, p0y);
         word_in.op_y[0] = dsub(vx, p0x);
         word_in.op_x[1] = dsub(vmin, p0y);
         word_in.op_y[1] = x_neg ? dsub(p0x, p1x) : dsub(p1x, p0x);
         word_in.op_x[2] = dsub(vmax, p0y);
         word_in.op_y[2] = x_neg ? dsub(p0x, p1x) : dsub(p1x, p0x);
      end else begin
         word_in.kind    = sit_pkg::KIND_GENERAL;
         word_in.pre_hit = 1'b0;
         // Cross products for the denominator and the two line parameters.
         word_in.op_x[0] = dsub(a_end_y, a_start_y);
         word_in.op_y[0] = dsub(b_end_x, b_start_x);
         word_in.op_x[1] = dsub(b_end_y, b_start_y);
         word_in.op_y[1] = dsub(a_end_x, a_start_x);
         word_in.op_x[2] = dsub(b_end_y, b_start_y);
         word_in.op_y[2] = dsub(a_start_x, b_start_x);
         word_in.op_x[3] = dsub(b_end_x, b_start_x);
         word_in.op_y[3] = dsub(a_start_y, b_start_y);
         word_in.op_x[4] = dsub(a_end_y, a_start_y);
         word_in.op_y[4] = dsub(b_start_x, a_start_x);
         word_in.op_x[5] = dsub(a_end_x, a_start_x);
         word_in.op_y[5] = dsub(b_start_y, a_start_y);
      end
      word_valid_in = accept;
   end

   // Front register: valid is control, the word is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign word_valid = word_valid_ff;
   assign word       = word_ff;

endmodule

/* rtl/sit_queue.sv */
// Short queue of classified words between front and back end.
// Depends on sit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sit_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  sit_pkg::mid_word_type            push_word,
   input  logic                             pop,
   output logic [sit_pkg::MID_CNT_BITS-1:0] level,
   output logic                             head_valid,
   output sit_pkg::mid_word_type            head_word
);

   sit_pkg::mid_word_type                   mem_ff [sit_pkg::MID_DEPTH];
   logic [sit_pkg::MID_PTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [sit_pkg::MID_PTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [sit_pkg::MID_CNT_BITS-1:0]        level_ff, level_in;

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + sit_pkg::MID_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + sit_pkg::MID_PTR_BITS'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   level_in = level_ff + sit_pkg::MID_CNT_BITS'(1);
         2'b01:   level_in = level_ff - sit_pkg::MID_CNT_BITS'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Storage is written at the tail only.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign level      = level_ff;
   assign head_valid = (level_ff != '0);
   assign head_word  = mem_ff[rd_ptr_ff];

   // The fill level never passes the depth, the front never pushes into a full
   // queue, and the back never pops an empty one.
   `ASSERT_PROP(a_mid_level_bound, clock, reset,
      level_ff <= sit_pkg::MID_CNT_BITS'(sit_pkg::MID_DEPTH))
   `ASSERT_NEVER(a_mid_push_full, clock, reset,
      push && (level_ff == sit_pkg::MID_CNT_BITS'(sit_pkg::MID_DEPTH)))
   `ASSERT_NEVER(a_mid_pop_empty, clock, reset, pop && (level_ff == '0))

endmodule

/* rtl/sit_back.sv */
// Back end of the segment intersection test: products, differences, final
// compares and the result queue. Depends on sit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sit_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  sit_pkg::mid_word_type head_word,
   output logic                  head_pop,
   input  logic                  pop,
   output logic                  empty,
   output logic                  hit,
   output sit_pkg::kind_type     case_kind
);

   // Product stage.
   logic              b1_valid_ff, b1_valid_in;
   sit_pkg::kind_type b1_kind_ff;
   logic              b1_pre_ff;
   sit_pkg::prod_type prod_ff [sit_pkg::NUM_PROD];
   sit_pkg::prod_type prod_in [sit_pkg::NUM_PROD];

   // Difference stage.
   logic              b2_valid_ff, b2_valid_in;
   sit_pkg::kind_type b2_kind_ff;
   logic              b2_flag_ff, b2_flag_in;
   sit_pkg::sum_type  den_ff, den_in, sa_ff, sa_in, sb_ff, sb_in;

   // Final decision.
   sit_pkg::sum_type  neg_den;
   logic              ratio_a, ratio_b;
   logic              res_hit;
   sit_pkg::kind_type res_kind;

   // Result queue.
   logic                              out_hit_ff [sit_pkg::OUT_DEPTH];
   sit_pkg::kind_type                 out_kind_ff [sit_pkg::OUT_DEPTH];
   logic [sit_pkg::OUT_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [sit_pkg::OUT_CNT_BITS-1:0]  count_ff, count_in;
   logic                              out_pop;
   logic [sit_pkg::OUT_CNT_BITS-1:0]  committed;

   // Take a word only when the result queue has room for it and all in flight.
   always_comb begin
      committed = count_ff + sit_pkg::OUT_CNT_BITS'(b1_valid_ff)
                  + sit_pkg::OUT_CNT_BITS'(b2_valid_ff);
      head_pop    = head_valid && (committed < sit_pkg::OUT_CNT_BITS'(sit_pkg::OUT_DEPTH));
      b1_valid_in = head_pop;
      b2_valid_in = b1_valid_ff;
   end

   // Six independent signed multiplies.
   always_comb begin
      for (int i = 0; i < sit_pkg::NUM_PROD; i++) begin
         prod_in[i] = $signed(head_word.op_x[i]) * $signed(head_word.op_y[i]);
      end
   end

   // Differences for the general case, range checks for one vertical segment, early flag for both vertical.
   always_comb begin
      den_in = sit_pkg::sum_type'(prod_ff[0]) - sit_pkg::sum_type'(prod_ff[1]);
      sa_in  = sit_pkg::sum_type'(prod_ff[2]) - sit_pkg::sum_type'(prod_ff[3]);
      sb_in  = sit_pkg::sum_type'(prod_ff[4]) - sit_pkg::sum_type'(prod_ff[5]);
      if (b1_kind_ff == sit_pkg::KIND_BOTH_VERT) begin
         b2_flag_in = b1_pre_ff;
      end else begin
         b2_flag_in = b1_pre_ff && (prod_ff[1] <= prod_ff[0]) && (prod_ff[0] <= prod_ff[2]);
      end
   end

   // Both line parameters must lie in the closed unit interval.
   always_comb begin
      neg_den = -den_ff;
      if (!den_ff[sit_pkg::SUM_BITS-1]) begin
         ratio_a = !sa_ff[sit_pkg::SUM_BITS-1] && (sa_ff <= den_ff);
         ratio_b = (sb_ff[sit_pkg::SUM_BITS-1] || (sb_ff == '0)) && (sb_ff >= neg_den);
      end else begin
         ratio_a = (sa_ff[sit_pkg::SUM_BITS-1] || (sa_ff == '0)) && (sa_ff >= den_ff);
         ratio_b = !sb_ff[sit_pkg::SUM_BITS-1] && (sb_ff <= neg_den);
      end
   end

   // Final hit flag and case code.
   always_comb begin
      res_kind = b2_kind_ff;
      res_hit  = 1'b0;
      case (b2_kind_ff) inside
         sit_pkg::KIND_BOTH_VERT,
         sit_pkg::KIND_A_VERT,
         sit_pkg::KIND_B_VERT: begin
            res_hit = b2_flag_ff;
         end
         sit_pkg::KIND_GENERAL: begin
            if (den_ff == '0) begin
               res_kind = sit_pkg::KIND_PARALLEL;
            end else begin
               res_hit = ratio_a && ratio_b;
            end
         end
         default: begin
            res_hit = 1'b0;
         end
      endcase
   end

   // Result queue pointers and count.
   always_comb begin
      out_pop   = pop && (count_ff != '0);
      wr_ptr_in = b2_valid_ff ? wr_ptr_ff + sit_pkg::OUT_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = out_pop ? rd_ptr_ff + sit_pkg::OUT_PTR_BITS'(1) : rd_ptr_ff;
      case ({b2_valid_ff, out_pop})
         2'b10:   count_in = count_ff + sit_pkg::OUT_CNT_BITS'(1);
         2'b01:   count_in = count_ff - sit_pkg::OUT_CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b2_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (head_pop) begin
         b1_kind_ff <= head_word.kind;
         b1_pre_ff  <= head_word.pre_hit;
         for (int i = 0; i < sit_pkg::NUM_PROD; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (b1_valid_ff) begin
         b2_kind_ff <= b1_kind_ff;
         b2_flag_ff <= b2_flag_in;
         den_ff     <= den_in;
         sa_ff      <= sa_in;
         sb_ff      <= sb_in;
      end
      if (b2_valid_ff) begin
         out_hit_ff[wr_ptr_ff]  <= res_hit;
         out_kind_ff[wr_ptr_ff] <= res_kind;
      end
   end

   assign empty     = (count_ff == '0);
   assign hit       = out_hit_ff[rd_ptr_ff];
   assign case_kind = out_kind_ff[rd_ptr_ff];

   // Credits cover every word in flight, the pipeline never stalls, and
   // parallel lines never report a hit.
   `ASSERT_PROP(a_out_credit, clock, reset,
      committed <= sit_pkg::OUT_CNT_BITS'(sit_pkg::OUT_DEPTH))
   `ASSERT_PROP(a_pipe_advance, clock, reset, b1_valid_ff |=> b2_valid_ff)
   `ASSERT_NEVER(a_parallel_hit, clock, reset,
      b2_valid_ff && (res_kind == sit_pkg::KIND_PARALLEL) && res_hit)

endmodule

/* rtl/segment_intersection_test.sv */
// Segment intersection test: one test per clock cycle, sustained when the consumer pops
// every cycle. A result reaches the rsp_ ports through the front register, queue write,
// product register, and difference register into the result queue.
// Six parallel multipliers set the rate, one pair of segments each cycle unless a queue fills.
// Synchronous active-high reset empties both queues and the pipeline; no clearing pass.
// Depends on sit_pkg, sit_front, sit_queue and sit_back.
module segment_intersection_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  sit_pkg::coord_type req_a_start_x,
   input  sit_pkg::coord_type req_a_start_y,
   input  sit_pkg::coord_type req_a_end_x,
   input  sit_pkg::coord_type req_a_end_y,
   input  sit_pkg::coord_type req_b_start_x,
   input  sit_pkg::coord_type req_b_start_y,
   input  sit_pkg::coord_type req_b_end_x,
   input  sit_pkg::coord_type req_b_end_y,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_hit,
   output logic [2:0]         rsp_case_kind
);

   logic [sit_pkg::MID_CNT_BITS-1:0] mid_level;
   logic                             front_valid;
   sit_pkg::mid_word_type            front_word;
   logic                             head_valid;
   sit_pkg::mid_word_type            head_word;
   logic                             head_pop;
   sit_pkg::kind_type                back_kind;

   // Front end: accept and classify.
   sit_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .a_start_x  (req_a_start_x),
      .a_start_y  (req_a_start_y),
      .a_end_x    (req_a_end_x),
      .a_end_y    (req_a_end_y),
      .b_start_x  (req_b_start_x),
      .b_start_y  (req_b_start_y),
      .b_end_x    (req_b_end_x),
      .b_end_y    (req_b_end_y),
      .mid_level  (mid_level),
      .word_valid (front_valid),
      .word       (front_word)
   );

   // Decoupling queue.
   sit_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_word  (front_word),
      .pop        (head_pop),
      .level      (mid_level),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   // Back end: arithmetic and result queue.
   sit_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_word  (head_word),
      .head_pop   (head_pop),
      .pop        (pop),
      .empty      (empty),
      .hit        (rsp_hit),
      .case_kind  (back_kind)
   );

   assign rsp_case_kind = back_kind;

endmodule
